### rtl/integer_to_radix_symbols_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to radix symbols core
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_SYMBOLS_CORE_DEFINES_SVH
`define INTEGER_TO_RADIX_SYMBOLS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ITRS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define ITRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITRS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define ITRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/itrs_pkg.sv
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared constants, types and state encoding of the radix symbol converter.
// ----------------------------------------------------------------------------
package itrs_pkg;

  localparam int unsigned MAX_SYMBOLS  = 16;
  localparam int unsigned SYMBOL_STORE = 16;
  localparam int unsigned SYM_LIMIT    =
    (MAX_SYMBOLS < SYMBOL_STORE) ? MAX_SYMBOLS : SYMBOL_STORE;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DIGIT_W   = $clog2(SYMBOL_STORE);
  localparam int unsigned RADIX_W   = DIGIT_W + 1;

  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned NDIG_W     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

  localparam int unsigned DIV_BITS  = 8;
  localparam int unsigned DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LENGTH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_LOAD,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [RADIX_W-1:0]   radix;
  } div_ctrl_t;

  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quotient;
    logic [DIGIT_W-1:0]   remainder;
  } div_stat_t;

endpackage

### rtl/integer_to_radix_symbols_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_symbols_core
// Converts a signed 32-bit integer to characters of a configured alphabet.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    value_i
// output    out        out_valid_o / out_stall_i  character_o, last_o
// config    in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One request is taken at a time; the block stalls its input until the last
// character of that request has been taken, or until the request is dropped
// because the alphabet is too short or holds a bad or repeated symbol.
// The alphabet check steps through the symbols in use; each digit is then
// one division by the radix on the single divider, lowest digit first.
// A load step follows, then one character per cycle while the output is not
// stalled. Reset clears config and control registers and idles the sequencer.
// ----------------------------------------------------------------------------
`include "integer_to_radix_symbols_core_defines.svh"

module integer_to_radix_symbols_core import itrs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [VALUE_W-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [CHAR_W-1:0]           character_o,
  output logic                        last_o
);

  logic [CFG_W-1:0]     symbols_low_q, symbols_high_q;
  logic [LEN_W-1:0]     alen_q;

  st_e                  state_q, state_d;
  logic [RADIX_W-1:0]   chk_q, chk_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic                 sign_q, sign_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic [NDIG_W-1:0]    nd_q, nd_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;
  logic [DIGIT_W-1:0]   digits_q [MAX_DIGITS];
  logic                 dig_we;

  logic [CHAR_W-1:0]    sym [SYMBOL_STORE];
  logic [RADIX_W-1:0]   n_eff;
  logic                 bad_sym;
  logic [NDIG_W-1:0]    nd_m1;
  logic                 in_acc, out_acc;

  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
      alen_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYMBOLS_LOW:     symbols_low_q  <= cfg_data_i;
        CFG_SYMBOLS_HIGH:    symbols_high_q <= cfg_data_i;
        CFG_ALPHABET_LENGTH: alen_q         <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [2*CFG_W-1:0] bits;
    logic [LEN_W-1:0]   limit;
    logic               stop;
    logic [CHAR_W-1:0]  c;
    bits  = {symbols_high_q, symbols_low_q};
    limit = (alen_q > LEN_W'(SYM_LIMIT)) ? LEN_W'(SYM_LIMIT) : alen_q;
    for (int i = 0; i < SYMBOL_STORE; i++) begin
      sym[i] = bits[CHAR_W*i +: CHAR_W];
    end
    n_eff = '0;
    stop  = 1'b0;
    for (int i = 0; i < SYMBOL_STORE; i++) begin
      if (!stop) begin
        if ((LEN_W'(i) < limit) && (sym[i] != '0)) begin
          n_eff = RADIX_W'(i + 1);
        end else begin
          stop = 1'b1;
        end
      end
    end
    c       = sym[chk_q[DIGIT_W-1:0]];
    bad_sym = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR)) ||
              (c == CHAR_PLUS) || (c == CHAR_MINUS);
    for (int j = 0; j < SYMBOL_STORE; j++) begin
      if ((RADIX_W'(j) > chk_q) && (RADIX_W'(j) < n_eff) && (sym[j] == c)) begin
        bad_sym = 1'b1;
      end
    end
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign nd_m1   = nd_q - NDIG_W'(1);

  always_comb begin
    logic load;
    state_d  = state_q;
    chk_d    = chk_q;
    mag_d    = mag_q;
    sign_d   = sign_q;
    radix_d  = radix_q;
    nd_d     = nd_q;
    char_d   = char_q;
    last_d   = last_q;
    dig_we   = 1'b0;
    load     = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = mag_q;
    div_ctrl.radix    = radix_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sign_d  = value_i[VALUE_W-1];
          mag_d   = value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;
          chk_d   = '0;
          nd_d    = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_eff < RADIX_W'(2)) begin
          state_d = ST_IDLE;
        end else if (chk_q >= n_eff) begin
          radix_d        = n_eff;
          div_ctrl.start = 1'b1;
          state_d        = ST_DIV;
        end else if (bad_sym) begin
          state_d = ST_IDLE;
        end else begin
          chk_d = chk_q + RADIX_W'(1);
        end
      end
      ST_DIV: begin
        div_ctrl.dividend = div_stat.quotient;
        if (div_stat.done) begin
          dig_we = 1'b1;
          nd_d   = nd_q + NDIG_W'(1);
          if (div_stat.quotient != '0) begin
            div_ctrl.start = 1'b1;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        load    = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            load = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      if (sign_q) begin
        char_d = CHAR_MINUS;
        last_d = 1'b0;
        sign_d = 1'b0;
      end else begin
        char_d = sym[digits_q[nd_m1[DIG_IDX_W-1:0]]];
        last_d = (nd_q == NDIG_W'(1));
        nd_d   = nd_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_q   <= '0;
      sign_q  <= 1'b0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      sign_q  <= sign_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    radix_q <= radix_d;
    char_q  <= char_d;
    last_q  <= last_d;
    if (dig_we) begin
      digits_q[nd_q[DIG_IDX_W-1:0]] <= div_stat.remainder;
    end
  end

  itrs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign character_o = char_q;
  assign last_o      = last_q;

  `ITRS_ASSERT_NEXT(a_ready_after_last, clk_i, rst_ni, out_acc && last_o, !in_stall_o, "block not ready after the last character")
  `ITRS_ASSERT_IMPL(a_digit_bound, clk_i, rst_ni, 1'b1, nd_q <= NDIG_W'(MAX_DIGITS), "digit count exceeds the digit store")
  `ITRS_ASSERT_IMPL(a_minus_not_last, clk_i, rst_ni, out_valid_o && (character_o == CHAR_MINUS), !last_o, "minus sign flagged as last character")
  `ITRS_ASSERT_IMPL(a_more_to_send, clk_i, rst_ni, out_valid_o && !last_o, sign_q || (nd_q != '0), "character not last but nothing left to send")
  `ITRS_ASSERT_IMPL(a_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV, "divider finished outside the division phase")

endmodule

### rtl/itrs_divider.sv
// ----------------------------------------------------------------------------
// itrs_divider
// Restoring divider by a small run-time radix, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module itrs_divider import itrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_ctrl_t ctrl_i,
  output div_stat_t stat_o
);

  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]  cnt_q;
  logic               busy_q;

  always_comb begin
    logic [RADIX_W-1:0] t;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      t     = {rem_d, quo_d[VALUE_W-1]};
      quo_d = {quo_d[VALUE_W-2:0], 1'b0};
      if (t >= ctrl_i.radix) begin
        t        = t - ctrl_i.radix;
        quo_d[0] = 1'b1;
      end
      rem_d = t[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= ctrl_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.done      = busy_q && (cnt_q == STEP_W'(DIV_STEPS - 1));
  assign stat_o.quotient  = quo_d;
  assign stat_o.remainder = rem_d;

endmodule
